// ===== hw/rtl/hchacha20_subkey_derive_core_assert.svh =====
// ----------------------------------------------------------------------------
// HChaCha20 subkey core assertion macros
// Concurrent assertion wrappers used by the core's built-in checks.
// ----------------------------------------------------------------------------
`ifndef HCHACHA20_SUBKEY_DERIVE_CORE_ASSERT_SVH
`define HCHACHA20_SUBKEY_DERIVE_CORE_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define HCSD_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("hcsd assertion failed");

// Condition in this cycle implies a consequence in the next cycle.
`define HCSD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("hcsd assertion failed");

`endif

// ===== hw/rtl/hcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 subkey package
// Shared types, constants and the per-cell quarter-round step function.
// ----------------------------------------------------------------------------
package hcsd_pkg;

  // Number of ChaCha rounds (8 to 20); each round takes four cells
  localparam int unsigned ROUND_COUNT = 20;
  localparam int unsigned NUM_CELLS   = ROUND_COUNT * 4;

  localparam int unsigned KEY_REGS  = 4;
  localparam int unsigned ADDR_W    = 5;

  typedef logic [15:0][31:0]         state_t;
  typedef logic [KEY_REGS-1:0][63:0] key_t;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // Configuration register indexes (paddr[4:3])
  typedef enum logic [1:0] {
    REG_KEY_0 = 2'd0,
    REG_KEY_1 = 2'd1,
    REG_KEY_2 = 2'd2,
    REG_KEY_3 = 2'd3
  } reg_idx_e;

  // One quarter-round step: add, xor, rotate
  typedef enum logic [1:0] {
    STEP_AB16 = 2'd0,
    STEP_CD12 = 2'd1,
    STEP_AB8  = 2'd2,
    STEP_CD7  = 2'd3
  } step_e;

  // Apply one step to all four quarter rounds of a column or diagonal round
  function automatic state_t cell_step(state_t s, step_e step, logic diag);
    state_t     r;
    logic [1:0] kk;
    logic [3:0] ia, ib, ic, id;
    logic [31:0] x;
    r = s;
    for (int k = 0; k < 4; k++) begin
      kk = 2'(k);
      ia = {2'b00, kk};
      ib = {2'b01, diag ? kk + 2'd1 : kk};
      ic = {2'b10, diag ? kk + 2'd2 : kk};
      id = {2'b11, diag ? kk + 2'd3 : kk};
      case (step)
        STEP_AB16: begin
          r[ia] = r[ia] + r[ib];
          x     = r[id] ^ r[ia];
          r[id] = {x[15:0], x[31:16]};
        end
        STEP_CD12: begin
          r[ic] = r[ic] + r[id];
          x     = r[ib] ^ r[ic];
          r[ib] = {x[19:0], x[31:20]};
        end
        STEP_AB8: begin
          r[ia] = r[ia] + r[ib];
          x     = r[id] ^ r[ia];
          r[id] = {x[23:0], x[31:24]};
        end
        default: begin
          r[ic] = r[ic] + r[id];
          x     = r[ib] ^ r[ic];
          r[ib] = {x[24:0], x[31:25]};
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hchacha20_subkey_derive_core.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 subkey derivation core
// Derives a 256-bit subkey from the session key and a 128-bit nonce.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 256-bit key through the APB port (four 64-bit registers at
//   byte addresses 0, 8, 16, 24) while no request is in flight.
//   Each nonce request on s_axis yields exactly one subkey on m_axis.
//   The rounds run in a chain of cells, one add/xor/rotate step per cell,
//   four cells per round: 80 cells for 20 rounds.
//   A request accepted on s_axis passes through every cell of the chain and
//   then the output register before it appears on m_axis_tvalid.
//   Throughput: one request per cycle while the receiver does not stall.
//   Reset clears all valid bits and sets the key registers to zero.
//   When m_axis stalls, all but the first cell hold; s_axis_tready stays
//   high only while the first cell is empty, so one more request can enter.
// ----------------------------------------------------------------------------
module hchacha20_subkey_derive_core
  import hcsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style key port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  // Nonce requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [127:0]      s_axis_tdata,   // nonce_low [63:0], nonce_high [127:64]
  // Subkey results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [255:0]      m_axis_tdata    // subkey_0..subkey_3, 64 bits each
);

  key_t                 key;
  state_t               init_state;
  logic [NUM_CELLS-1:0] cell_valid;
  state_t               cell_state [NUM_CELLS];
  logic                 pipe_en;
  logic                 first_en;
  logic                 out_valid_q;
  logic [255:0]         out_data_q;
  state_t               last_state;

  hcsd_key_regs u_key_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  // Chain advances whenever the output register is free or being drained
  assign pipe_en       = !out_valid_q || m_axis_tready;
  assign first_en      = pipe_en || !cell_valid[0];
  assign s_axis_tready = first_en;

  // Initial ChaCha state: constants, key, nonce
  always_comb begin
    init_state[0]  = SIGMA_0;
    init_state[1]  = SIGMA_1;
    init_state[2]  = SIGMA_2;
    init_state[3]  = SIGMA_3;
    for (int w = 0; w < KEY_REGS; w++) begin
      init_state[4 + 2*w] = key[w][31:0];
      init_state[5 + 2*w] = key[w][63:32];
    end
    init_state[12] = s_axis_tdata[31:0];
    init_state[13] = s_axis_tdata[63:32];
    init_state[14] = s_axis_tdata[95:64];
    init_state[15] = s_axis_tdata[127:96];
  end

  // Cell chain: cell i runs step i%4 of round i/4
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      hcsd_round_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (first_en),
        .step_i  (step_e'(2'(i % 4))),
        .diag_i  (1'((i / 4) % 2)),
        .valid_i (s_axis_tvalid),
        .state_i (init_state),
        .valid_o (cell_valid[i]),
        .state_o (cell_state[i])
      );
    end else begin : g_next
      hcsd_round_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (pipe_en),
        .step_i  (step_e'(2'(i % 4))),
        .diag_i  (1'((i / 4) % 2)),
        .valid_i (cell_valid[i-1]),
        .state_i (cell_state[i-1]),
        .valid_o (cell_valid[i]),
        .state_o (cell_state[i])
      );
    end
  end

  assign last_state = cell_state[NUM_CELLS-1];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= cell_valid[NUM_CELLS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && cell_valid[NUM_CELLS-1]) begin
      out_data_q <= {last_state[15], last_state[14], last_state[13], last_state[12],
                     last_state[3],  last_state[2],  last_state[1],  last_state[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `include "hchacha20_subkey_derive_core_assert.svh"

  `HCSD_ASSERT_NEXT(a_accept_fills_first, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready, cell_valid[0])
  `HCSD_ASSERT_NEXT(a_stall_holds_chain, clk_i, rst_ni,
                    !pipe_en, $stable(cell_valid[NUM_CELLS-1:1]))
  `HCSD_ASSERT_NEXT(a_last_reaches_out, clk_i, rst_ni,
                    pipe_en && cell_valid[NUM_CELLS-1], out_valid_q)
  `HCSD_ASSERT_NOW(a_ready_low_only_full, clk_i, rst_ni,
                   !s_axis_tready, out_valid_q && !m_axis_tready && cell_valid[0])

endmodule

// ===== hw/rtl/hcsd_key_regs.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 key register bank
// Four 64-bit key registers behind an APB-style port.
// ----------------------------------------------------------------------------
module hcsd_key_regs
  import hcsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output key_t              key_o
);

  key_t     key_q;
  key_t     key_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode
  always_comb begin
    key_d = key_q;
    if (wr_en) begin
      unique case (idx)
        REG_KEY_0: key_d[0] = pwdata;
        REG_KEY_1: key_d[1] = pwdata;
        REG_KEY_2: key_d[2] = pwdata;
        REG_KEY_3: key_d[3] = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_KEY_0: prdata = key_q[0];
      REG_KEY_1: prdata = key_q[1];
      REG_KEY_2: prdata = key_q[2];
      REG_KEY_3: prdata = key_q[3];
    endcase
  end

  assign key_o = key_q;

endmodule

// ===== hw/rtl/hcsd_round_cell.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 round cell
// One quarter-round step over the full state, registered, with a valid bit.
// ----------------------------------------------------------------------------
module hcsd_round_cell
  import hcsd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  step_e  step_i,
  input  logic   diag_i,
  input  logic   valid_i,
  input  state_t state_i,
  output logic   valid_o,
  output state_t state_o
);

  logic   valid_q;
  state_t state_q;
  state_t state_d;

  assign state_d = cell_step(state_i, step_i, diag_i);

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // State payload, loaded only for a live request
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
